// File: rtl/rtcq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcq_pkg: shared types and constants for the rectangle table query unit
// Holds the table depth, operation and status codes and the word formats.
// ----------------------------------------------------------------------------
package rtcq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND_DEF = 3'd0,
    OP_APPEND_SZ  = 3'd1,
    OP_POP        = 3'd2,
    OP_ERASE      = 3'd3,
    OP_MOVE       = 3'd4,
    OP_RECT_Q     = 3'd5,
    OP_CIRCLE_Q   = 3'd6,
    OP_POINT_Q    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
    logic [14:0]        radius;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic       hit;
    logic [5:0] hit_index;
    logic [6:0] entry_total;
    logic       last;
  } rsp_t;

endpackage : rtcq_pkg
`default_nettype wire

// File: rtl/rect_table_collision_query_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_table_collision_query_unit: rectangle table with collision queries
// Keeps an ordered table of boxes and answers rect, circle and point queries.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req) carries one operation. It is taken when req_valid and
// req_ready are both high; req_ready is high only while the sequencer is idle.
// Every request yields response words on rsp; a query yields one word per
// hit in table order, or one no-hit word, and the final word has last set.
// Append, pop and move pass S_OUT to the response. Erase passes S_ERS and
// S_ERW per entry moved down. Rect and point queries pass S_QRD and S_QEV
// per stored entry, circle queries also S_SQX and S_SQY, because one squaring
// multiplier is shared for dx*dx and dy*dy and the table has one read port.
// A new request is taken the cycle after the last response word is loaded,
// so the output register may still hold that word while the next one starts.
// If the receiver stalls, the sequencer waits with its next word until the
// output register is free; nothing is dropped.
// Reset (rst, synchronous) empties the table and clears the default size
// registers. The default sizes are written over the APB port at byte
// addresses 0 (width) and 4 (height).
// ----------------------------------------------------------------------------
module rect_table_collision_query_unit
  import rtcq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_ready,
  input  wire req_t        req,
  output      logic        rsp_valid,
  input  wire logic        rsp_ready,
  output      rsp_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OUT  = 9'b000000010,
    S_ERS  = 9'b000000100,
    S_ERW  = 9'b000001000,
    S_QRD  = 9'b000010000,
    S_QEV  = 9'b000100000,
    S_SQX  = 9'b001000000,
    S_SQY  = 9'b010000000,
    S_QEND = 9'b100000000
  } state_t;

  // Separate hit state is folded in: S_QEV/S_SQY set hitf, S_QRD acts on it.
  state_t state;

  logic [14:0] dw, dh;
  logic [CW-1:0] cnt, ptr;
  op_t op_r;
  logic signed [15:0] px, py;
  logic [14:0] sw, sh;
  logic [29:0] rsq;
  logic signed [17:0] dx, dy;
  logic [35:0] acc;
  logic hitf, hitp;
  logic pend_v;
  logic [AW-1:0] pend_idx;
  status_t stat;

  // Table memory: position and size kept apart so a move writes only x, y.
  logic [31:0] pos_mem [TABLE_DEPTH];
  logic [29:0] size_mem [TABLE_DEPTH];
  logic [31:0] rd_pos;
  logic [29:0] rd_size;
  logic pos_we, size_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0] wr_pos;
  logic [29:0] wr_size;
  logic [CW-1:0] ptr_inc;

  logic accept, ob_free, full;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign ob_free   = !rsp_valid || rsp_ready;
  assign full      = (cnt == CW'(TABLE_DEPTH));
  assign ptr_inc   = ptr + CW'(1);
  assign pready    = 1'b1;
  assign hitp      = hitf && pend_v;

  // Register read back.
  assign prdata = paddr[2] ? {17'b0, dh} : {17'b0, dw};

  // Memory write port and read address selection.
  always_comb begin
    pos_we  = 1'b0;
    size_we = 1'b0;
    wr_addr = cnt[AW-1:0];
    wr_pos  = {req.pos_x, req.pos_y};
    wr_size = (req.op == OP_APPEND_DEF) ? {dw, dh} : {req.size_w, req.size_h};
    if (accept && (req.op == OP_APPEND_DEF || req.op == OP_APPEND_SZ) && !full) begin
      pos_we  = 1'b1;
      size_we = 1'b1;
    end else if (accept && req.op == OP_MOVE && CW'(req.index) < cnt) begin
      pos_we  = 1'b1;
      wr_addr = req.index;
    end else if (state == S_ERW) begin
      pos_we  = 1'b1;
      size_we = 1'b1;
      wr_addr = ptr[AW-1:0];
      wr_pos  = rd_pos;
      wr_size = rd_size;
    end
    rd_addr = (state == S_ERS) ? ptr_inc[AW-1:0] : ptr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= wr_pos;
    end
    if (size_we) begin
      size_mem[wr_addr] <= wr_size;
    end
    rd_pos  <= pos_mem[rd_addr];
    rd_size <= size_mem[rd_addr];
  end

  // Shared squaring unit: radius at accept, then dx and dy per entry.
  logic signed [17:0] mul_a;
  logic signed [35:0] prod;
  always_comb begin
    unique case (state)
      S_SQX:   mul_a = dx;
      S_SQY:   mul_a = dy;
      default: mul_a = signed'({3'b0, req.radius});
    endcase
  end
  assign prod = mul_a * mul_a;

  // Entry evaluation on the registered read data, at 18-bit full precision.
  logic signed [17:0] ex, ey, ex2, ey2, qx, qy, qx2, qy2, cx, cy;
  logic hit_rect, hit_point;
  always_comb begin
    ex  = 18'(signed'(rd_pos[31:16]));
    ey  = 18'(signed'(rd_pos[15:0]));
    ex2 = ex + signed'({3'b0, rd_size[29:15]});
    ey2 = ey + signed'({3'b0, rd_size[14:0]});
    qx  = 18'(px);
    qy  = 18'(py);
    qx2 = qx + signed'({3'b0, sw});
    qy2 = qy + signed'({3'b0, sh});
    hit_rect  = !(ex >= qx2) && !(ex2 <= qx) && !(ey >= qy2) && !(ey2 <= qy);
    hit_point = (qx <= ex2) && (qx >= ex) && (qy <= ey2) && (qy >= ey);
    cx = (qx < ex) ? ex : ((qx > ex2) ? ex2 : qx);
    cy = (qy < ey) ? ey : ((qy > ey2) ? ey2 : qy);
  end

  logic [36:0] dist_sq;
  assign dist_sq = {1'b0, acc} + {1'b0, prod[35:0]};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      dw        <= '0;
      dh        <= '0;
      pend_v    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        if (paddr[2]) begin
          dh <= pwdata[14:0];
        end else begin
          dw <= pwdata[14:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r   <= req.op;
            px     <= req.pos_x;
            py     <= req.pos_y;
            sw     <= req.size_w;
            sh     <= req.size_h;
            rsq    <= prod[29:0];
            stat   <= ST_DONE;
            ptr    <= CW'(req.index);
            pend_v <= 1'b0;
            hitf   <= 1'b0;
            unique case (req.op)
              OP_APPEND_DEF, OP_APPEND_SZ: begin
                if (full) begin
                  stat <= ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
                state <= S_OUT;
              end
              OP_POP: begin
                if (cnt != '0) begin
                  cnt <= cnt - CW'(1);
                end
                state <= S_OUT;
              end
              OP_ERASE: begin
                if (CW'(req.index) >= cnt) begin
                  stat  <= ST_BADIDX;
                  state <= S_OUT;
                end else begin
                  state <= S_ERS;
                end
              end
              OP_MOVE: begin
                if (CW'(req.index) >= cnt) begin
                  stat <= ST_BADIDX;
                end
                state <= S_OUT;
              end
              OP_RECT_Q, OP_CIRCLE_Q, OP_POINT_Q: begin
                ptr   <= '0;
                state <= S_QRD;
              end
            endcase
          end
        end
        S_OUT: begin
          if (ob_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: stat, hit: 1'b0, hit_index: '0,
                           entry_total: cnt, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        // Erase: copy entry ptr+1 down to ptr until the end of the table.
        S_ERS: begin
          if (ptr_inc < cnt) begin
            state <= S_ERW;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_OUT;
          end
        end
        S_ERW: begin
          ptr   <= ptr_inc;
          state <= S_ERS;
        end
        // Query scan: act on the previous entry's hit, then read the next one.
        S_QRD: begin
          if (hitp && !ob_free) begin
            state <= S_QRD;
          end else begin
            if (hitf) begin
              if (pend_v) begin
                rsp_valid <= 1'b1;
                rsp       <= '{status: ST_DONE, hit: 1'b1, hit_index: pend_idx,
                               entry_total: cnt, last: 1'b0};
              end
              pend_v   <= 1'b1;
              pend_idx <= ptr[AW-1:0] - AW'(1);
            end
            hitf  <= 1'b0;
            state <= (ptr < cnt) ? S_QEV : S_QEND;
          end
        end
        S_QEV: begin
          dx <= qx - cx;
          dy <= qy - cy;
          ptr <= ptr_inc;
          if (op_r == OP_CIRCLE_Q) begin
            state <= S_SQX;
          end else begin
            hitf  <= (op_r == OP_RECT_Q) ? hit_rect : hit_point;
            state <= S_QRD;
          end
        end
        S_SQX: begin
          acc   <= prod[35:0];
          state <= S_SQY;
        end
        S_SQY: begin
          hitf  <= (dist_sq <= {7'b0, rsq});
          state <= S_QRD;
        end
        S_QEND: begin
          if (ob_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: ST_DONE, hit: pend_v,
                           hit_index: pend_v ? pend_idx : '0,
                           entry_total: cnt, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The table never holds more entries than it has room for.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH)) else $error("entry count past table depth");

  // A hit always names an entry that is inside the table.
  a_hit_in_table: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> CW'(rsp.hit_index) < rsp.entry_total)
    else $error("hit index outside table");

  // The entry count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) ||
                     cnt == $past(cnt) - CW'(1)))
    else $error("entry count jumped");

  // After a request is taken the sequencer is busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("ready after accept");
`endif

endmodule : rect_table_collision_query_unit
`default_nettype wire

// File: dv/rect_table_collision_query_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_table_collision_query_unit_tb: self-checking bench for the box table
// Drives table edits and collision queries with random gaps, predicts every
// response word from a local copy of the table and checks each field.
// ----------------------------------------------------------------------------
module rect_table_collision_query_unit_tb;
  import rtcq_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_s;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  req_t  pending_reqs[$];
  rsp_t  expected_rsps[$];
  box_s  boxes[TABLE_DEPTH];
  int    box_count = 0;
  int    dflt_w;
  int    dflt_h;
  int    errors = 0;
  int    cycles = 0;
  int    send_gap;
  int    recv_gap;
  int    reqs_sent = 0;
  int    reqs_taken = 0;
  int    rsps_seen = 0;
  int    rsps_taken = 0;
  int    rsp_draw;

  rect_table_collision_query_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rect_table_collision_query_unit_tb failed");
      $finish;
    end
  end

  // Tests one stored box against a query.
  function automatic bit collides(req_t q, box_s e);
    longint px, py, ex2, ey2, cx, cy, dx, dy, r;
    px = q.pos_x;
    py = q.pos_y;
    ex2 = e.x + e.w;
    ey2 = e.y + e.h;
    case (q.op)
      OP_RECT_Q: begin
        return !(e.x >= px + longint'(q.size_w) || ex2 <= px ||
                 e.y >= py + longint'(q.size_h) || ey2 <= py);
      end
      OP_CIRCLE_Q: begin
        cx = px < e.x ? e.x : (px > ex2 ? ex2 : px);
        cy = py < e.y ? e.y : (py > ey2 ? ey2 : py);
        dx = px - cx;
        dy = py - cy;
        r = q.radius;
        return dx * dx + dy * dy <= r * r;
      end
      default: begin
        return px <= ex2 && px >= e.x && py <= ey2 && py >= e.y;
      end
    endcase
  endfunction

  // Queues one request for the driver.
  task automatic add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  // Updates the table copy and queues the response words for one request.
  task automatic predict_table_op(req_t q);
    rsp_t    w;
    status_t st;
    int      hits;
    st = ST_DONE;
    hits = 0;
    w = '0;
    case (q.op)
      OP_APPEND_DEF, OP_APPEND_SZ: begin
        if (box_count >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          boxes[box_count].x = q.pos_x;
          boxes[box_count].y = q.pos_y;
          boxes[box_count].w = q.op == OP_APPEND_DEF ? dflt_w : int'(q.size_w);
          boxes[box_count].h = q.op == OP_APPEND_DEF ? dflt_h : int'(q.size_h);
          box_count++;
        end
      end
      OP_POP: begin
        if (box_count > 0) box_count--;
      end
      OP_ERASE: begin
        if (q.index >= box_count) begin
          st = ST_BADIDX;
        end else begin
          for (int i = q.index; i + 1 < box_count; i++) boxes[i] = boxes[i + 1];
          box_count--;
        end
      end
      OP_MOVE: begin
        if (q.index >= box_count) begin
          st = ST_BADIDX;
        end else begin
          boxes[q.index].x = q.pos_x;
          boxes[q.index].y = q.pos_y;
        end
      end
      default: begin
        for (int i = 0; i < box_count; i++) begin
          if (collides(q, boxes[i])) begin
            w.status = ST_DONE;
            w.hit = 1'b1;
            w.hit_index = 6'(i);
            w.entry_total = 7'(box_count);
            w.last = 1'b0;
            expected_rsps.insert(expected_rsps.size(), w);
            hits++;
          end
        end
        if (hits > 0) begin
          expected_rsps[expected_rsps.size() - 1].last = 1'b1;
          return;
        end
      end
    endcase
    w.status = st;
    w.hit = 1'b0;
    w.hit_index = '0;
    w.entry_total = 7'(box_count);
    w.last = 1'b1;
    expected_rsps.insert(expected_rsps.size(), w);
  endtask

  // Request driver: valid held until the word is taken, then a random gap.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      send_gap <= 0;
    end else if (req_valid) begin
      if (reqs_taken == reqs_sent) begin
        req_valid <= 1'b0;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req <= pending_reqs.pop_front();
      req_valid <= 1'b1;
      reqs_sent <= reqs_sent + 1;
    end
  end

  // Response side: random stall after each word.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap <= 0;
    end else if (rsps_seen != rsps_taken) begin
      rsps_seen <= rsps_taken;
      rsp_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (rsp_draw > 0) begin
        rsp_ready <= 1'b0;
        recv_gap <= rsp_draw - 1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end else if (recv_gap > 0) begin
      rsp_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Monitor: request acceptance feeds the predictor, responses are checked.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      predict_table_op(req);
      reqs_taken <= reqs_taken + 1;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response word %p", rsp);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.hit !== e.hit) begin
          $error("hit expected %0d actual %0d", e.hit, rsp.hit);
          errors++;
        end
        if (rsp.hit_index !== e.hit_index) begin
          $error("hit_index expected %0d actual %0d", e.hit_index, rsp.hit_index);
          errors++;
        end
        if (rsp.entry_total !== e.entry_total) begin
          $error("entry_total expected %0d actual %0d", e.entry_total,
                 rsp.entry_total);
          errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, rsp.last);
          errors++;
        end
      end
      rsps_taken <= rsps_taken + 1;
    end
  end

  // One APB register write: setup cycle, then access cycle.
  task automatic write_reg(int idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == 0) dflt_w = value[14:0];
    else dflt_h = value[14:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every queued request is taken and answered, then a pause.
  task automatic drain();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic req_t make_req(op_t op, int idx, int x, int y, int w, int h,
                                    int r);
    req_t q;
    q.op = op;
    q.index = 6'(idx);
    q.pos_x = 16'(x);
    q.pos_y = 16'(y);
    q.size_w = 15'(w);
    q.size_h = 15'(h);
    q.radius = 15'(r);
    return q;
  endfunction

  // Coordinates mostly clustered so that queries hit often.
  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom())));
    return int'($urandom_range(0, 400)) - 200;
  endfunction

  function automatic int rand_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 32767);
    return $urandom_range(0, 120);
  endfunction

  function automatic req_t rand_req(int count);
    op_t op;
    int  sel;
    int  idx;
    sel = $urandom_range(0, 99);
    if (sel < 22) op = OP_APPEND_SZ;
    else if (sel < 30) op = OP_APPEND_DEF;
    else if (sel < 36) op = OP_POP;
    else if (sel < 44) op = OP_ERASE;
    else if (sel < 52) op = OP_MOVE;
    else if (sel < 70) op = OP_RECT_Q;
    else if (sel < 85) op = OP_CIRCLE_Q;
    else op = OP_POINT_Q;
    if (count > 0 && $urandom_range(0, 4) != 0) idx = $urandom_range(0, count - 1);
    else idx = $urandom_range(0, 63);
    return make_req(op, idx, rand_coord(), rand_coord(), rand_size(), rand_size(),
                    $urandom_range(0, 9) == 0 ? $urandom_range(0, 32767)
                                              : $urandom_range(0, 150));
  endfunction

  // Queues a burst of random requests, tracking a rough table size.
  task automatic random_phase(int n);
    req_t q;
    int   est;
    est = box_count;
    for (int i = 0; i < n; i++) begin
      q = rand_req(est);
      case (q.op)
        OP_APPEND_DEF, OP_APPEND_SZ: if (est < TABLE_DEPTH) est++;
        OP_POP: if (est > 0) est--;
        OP_ERASE: if (q.index < est) est--;
        default: ;
      endcase
      add_req(q);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dflt_w = 0;
    dflt_h = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table cases, extremes and every operation.
    add_req(make_req(OP_POP, 0, 0, 0, 0, 0, 0));
    add_req(make_req(OP_ERASE, 0, 0, 0, 0, 0, 0));
    add_req(make_req(OP_MOVE, 63, 0, 0, 0, 0, 0));
    add_req(make_req(OP_POINT_Q, 0, 0, 0, 0, 0, 0));
    add_req(make_req(OP_APPEND_DEF, 0, -32768, 32767, 0, 0, 0));
    add_req(make_req(OP_APPEND_SZ, 0, 32767, -32768, 32767, 32767, 0));
    add_req(make_req(OP_APPEND_SZ, 0, -10, -10, 20, 20, 0));
    add_req(make_req(OP_RECT_Q, 0, -32768, -32768, 32767, 32767, 0));
    add_req(make_req(OP_RECT_Q, 0, 10, -10, 5, 20, 0));
    add_req(make_req(OP_POINT_Q, 0, 10, 10, 0, 0, 0));
    add_req(make_req(OP_CIRCLE_Q, 0, 32767, 32767, 0, 0, 32767));
    add_req(make_req(OP_CIRCLE_Q, 0, 13, 14, 0, 0, 5));
    add_req(make_req(OP_CIRCLE_Q, 0, 13, 14, 0, 0, 4));
    add_req(make_req(OP_MOVE, 2, 100, 100, 0, 0, 0));
    add_req(make_req(OP_ERASE, 3, 0, 0, 0, 0, 0));
    add_req(make_req(OP_ERASE, 0, 0, 0, 0, 0, 0));
    add_req(make_req(OP_POINT_Q, 0, 32767, 32767, 0, 0, 0));
    drain();

    // Fill the table to overflow, query everything, erase the last and first entries, then pop past empty.
    write_reg(0, 32'h7fff);
    write_reg(1, 32'h7fff);
    for (int i = 0; i < 66; i++)
      add_req(make_req(OP_APPEND_DEF, 0, -32768 + i, -32768, 0, 0, 0));
    add_req(make_req(OP_POINT_Q, 0, 0, 0, 0, 0, 0));
    add_req(make_req(OP_ERASE, 63, 0, 0, 0, 0, 0));
    add_req(make_req(OP_ERASE, 0, 0, 0, 0, 0, 0));
    drain();
    for (int i = 0; i < 70; i++) add_req(make_req(OP_POP, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases under several default size settings.
    write_reg(0, 32'd40);
    write_reg(1, 32'd25);
    random_phase(85);
    write_reg(0, 32'd0);
    write_reg(1, 32'd0);
    random_phase(85);
    write_reg(0, $urandom_range(0, 32767));
    write_reg(1, $urandom_range(0, 200));
    random_phase(85);

    if (errors == 0) begin
      $display("rect_table_collision_query_unit_tb passed");
    end else begin
      $display("rect_table_collision_query_unit_tb failed");
    end
    $finish;
  end

endmodule
